@@ rtl/core/mrtu_pkg.sv @@
package mrtu_pkg;

    localparam int MAX_FRAME_DEFAULT = 64;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] FN_READ     = 8'h03;
    localparam logic [7:0] FN_WRITE    = 8'h06;
    localparam logic [7:0] READ_LENGTH = 8'd5;

    localparam logic [7:0] OWN_ADDRESS_RST = 8'd1;
    localparam logic [7:0] BCAST_ADDRESS_RST = 8'd0;
    localparam logic [7:0] IDLE_TICKS_RST = 8'd4;
    localparam logic [7:0] GAP_TICKS_RST = 8'd2;
    localparam logic [7:0] MIN_LENGTH_RST = 8'd4;

    localparam int CFG_ADDR_W = 5;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [2:0] REG_OWN_ADDRESS   = 3'd0;
    localparam logic [2:0] REG_BCAST_ADDRESS = 3'd1;
    localparam logic [2:0] REG_IDLE_TICKS    = 3'd2;
    localparam logic [2:0] REG_GAP_TICKS     = 3'd3;
    localparam logic [2:0] REG_MIN_LENGTH    = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_RECEIVE,
        MODE_ERROR,
        MODE_IGNORE
    } t_mode;

    typedef enum logic [2:0] {
        VERDICT_READ_OK,
        VERDICT_WRITE_OK,
        VERDICT_BAD_FUNCTION,
        VERDICT_READ_LENGTH,
        VERDICT_CRC_BAD,
        VERDICT_SHORT,
        VERDICT_OVERRUN
    } t_verdict;

    typedef struct packed {
        logic [7:0] own_address;
        logic [7:0] broadcast_address;
        logic [7:0] idle_ticks;
        logic [7:0] gap_ticks;
        logic [7:0] min_length;
    } t_cfg;

    typedef struct packed {
        logic       is_broadcast;
        t_verdict   verdict;
        logic [7:0] frame_length;
        logic [7:0] first_data;
        logic [7:0] register_addr;
        logic [7:0] function_code;
        logic [7:0] station;
    } t_result;

    // One byte of the reflected CRC-16 used by Modbus RTU.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/core/mrtu_regs.sv @@
module mrtu_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mrtu_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output mrtu_pkg::t_cfg                    o_cfg
);
    import mrtu_pkg::*;

    t_cfg r_cfg;
    logic [2:0] reg_index;
    logic [7:0] read_value;

    assign reg_index = paddr[CFG_ADDR_W-1:2];
    assign pready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.own_address       <= OWN_ADDRESS_RST;
            r_cfg.broadcast_address <= BCAST_ADDRESS_RST;
            r_cfg.idle_ticks        <= IDLE_TICKS_RST;
            r_cfg.gap_ticks         <= GAP_TICKS_RST;
            r_cfg.min_length        <= MIN_LENGTH_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_index)
                REG_OWN_ADDRESS:   r_cfg.own_address       <= pwdata[7:0];
                REG_BCAST_ADDRESS: r_cfg.broadcast_address <= pwdata[7:0];
                REG_IDLE_TICKS:    r_cfg.idle_ticks        <= pwdata[7:0];
                REG_GAP_TICKS:     r_cfg.gap_ticks         <= pwdata[7:0];
                REG_MIN_LENGTH:    r_cfg.min_length        <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_OWN_ADDRESS:   read_value = r_cfg.own_address;
            REG_BCAST_ADDRESS: read_value = r_cfg.broadcast_address;
            REG_IDLE_TICKS:    read_value = r_cfg.idle_ticks;
            REG_GAP_TICKS:     read_value = r_cfg.gap_ticks;
            REG_MIN_LENGTH:    read_value = r_cfg.min_length;
            default:           read_value = 8'h00;
        endcase
    end

    assign prdata = {24'h000000, read_value};

endmodule

@@ rtl/core/modbus_rtu_frame_receiver.sv @@
// Modbus RTU slave frame receiver.
// Input stream: each item is either a received byte (i_s_tuser = 0, byte in
// i_s_tdata) or one timer tick (i_s_tuser = 1). Frames addressed to the own or
// the broadcast station are counted and checked with a running CRC-16; frames
// for other stations are skipped until the line has been silent.
// Output stream: one item per addressed frame, issued on the tick that
// follows idle_ticks ticks of silence. It carries the verdict and the first
// four frame bytes together with the frame length. Every item is processed
// in the cycle it is accepted, so one item per cycle is sustained while
// o_s_tready is high; the per-byte CRC update is a single combinational step.
// Results go to the output register, or to the skid entry while it stalls.
// An output register plus a one-entry skid buffer sit behind the state logic.
// While the downstream side stalls, input items keep being taken until the
// skid entry also fills; o_s_tready then drops until the output moves.
// Synchronous reset returns the receiver to idle, clears both output entries
// and loads the configuration registers with their defaults. The APB port
// writes registers in its access phase and always answers with pready high.
module modbus_rtu_frame_receiver #(
    parameter int MAX_FRAME = mrtu_pkg::MAX_FRAME_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [7:0]                      i_s_tdata,  // [7:0] rx_byte
    input  logic                            i_s_tuser,  // [0] operation
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // [7:0] station, [15:8] function_code, [23:16] register_addr,
    // [31:24] first_data, [39:32] frame_length
    output logic [39:0]                     o_m_tdata,
    output logic [3:0]                      o_m_tuser,  // [2:0] verdict, [3] is_broadcast
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mrtu_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import mrtu_pkg::*;

    localparam logic [7:0] MaxFrame = 8'(MAX_FRAME);

    t_cfg       cfg;
    t_mode      r_mode, n_mode;
    logic [7:0] r_count, n_count;
    logic [7:0] r_silence, n_silence;
    logic [15:0] r_crc, n_crc;
    logic [7:0] r_hdr [4];
    logic [3:0] hdr_we;

    logic       in_fire;
    logic       is_byte;
    logic       addr_match;
    logic       gap_ok;
    logic       silence_done;
    logic       res_valid;
    t_result    res;
    t_verdict   verdict;

    logic       r_out_valid;
    t_result    r_out;
    logic       r_skid_valid;
    t_result    r_skid;
    logic       out_fire;

    mrtu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_s_tready   = !r_skid_valid;
    assign in_fire      = i_s_tvalid && o_s_tready;
    assign is_byte      = !i_s_tuser;
    assign addr_match   = (i_s_tdata == cfg.own_address)
                       || (i_s_tdata == cfg.broadcast_address);
    assign gap_ok       = r_silence < cfg.gap_ticks;
    assign silence_done = r_silence >= cfg.idle_ticks;

    // Next receive mode.
    always_comb begin
        n_mode = r_mode;
        if (in_fire) begin
            if (is_byte) begin
                case (r_mode)
                    MODE_IDLE:    n_mode = addr_match ? MODE_RECEIVE : MODE_IGNORE;
                    MODE_RECEIVE: begin
                        if (!(r_count < MaxFrame && gap_ok)) begin
                            n_mode = MODE_ERROR;
                        end
                    end
                    default:      n_mode = r_mode;
                endcase
            end else if (r_mode != MODE_IDLE && silence_done) begin
                n_mode = MODE_IDLE;
            end
        end
    end

    // Counters, CRC, header capture and the verdict strobe.
    always_comb begin
        n_count   = r_count;
        n_silence = r_silence;
        n_crc     = r_crc;
        hdr_we    = 4'b0000;
        res_valid = 1'b0;
        if (in_fire) begin
            if (is_byte) begin
                n_silence = 8'd0;
                case (r_mode)
                    MODE_IDLE: begin
                        if (addr_match) begin
                            n_count   = 8'd1;
                            hdr_we[0] = 1'b1;
                            n_crc     = crc16_byte(CRC_INIT, i_s_tdata);
                        end
                    end
                    MODE_RECEIVE: begin
                        if (r_count < 8'd4) begin
                            hdr_we[r_count[1:0]] = 1'b1;
                        end
                        if (r_count < MaxFrame && gap_ok) begin
                            n_crc = crc16_byte(r_crc, i_s_tdata);
                        end
                        if (r_count != 8'hFF) begin
                            n_count = r_count + 8'd1;
                        end
                    end
                    default: ;
                endcase
            end else if (r_mode != MODE_IDLE) begin
                if (!silence_done) begin
                    n_silence = r_silence + 8'd1;
                end else begin
                    n_count = 8'd0;
                    if (r_mode != MODE_IGNORE) begin
                        res_valid = 1'b1;
                        n_crc     = CRC_INIT;
                    end
                end
            end
        end
    end

    always_comb begin
        if (r_mode == MODE_ERROR) begin
            verdict = VERDICT_OVERRUN;
        end else if (r_count <= cfg.min_length) begin
            verdict = VERDICT_SHORT;
        end else if (r_crc != 16'h0000) begin
            verdict = VERDICT_CRC_BAD;
        end else if (r_count > 8'd1 && r_hdr[1] == FN_READ) begin
            verdict = (r_count == READ_LENGTH) ? VERDICT_READ_OK : VERDICT_READ_LENGTH;
        end else if (r_count > 8'd1 && r_hdr[1] == FN_WRITE) begin
            verdict = VERDICT_WRITE_OK;
        end else begin
            verdict = VERDICT_BAD_FUNCTION;
        end
    end

    // Header bytes past the end of the frame read as zero.
    always_comb begin
        res.verdict       = verdict;
        res.station       = (r_count > 8'd0) ? r_hdr[0] : 8'h00;
        res.function_code = (r_count > 8'd1) ? r_hdr[1] : 8'h00;
        res.register_addr = (r_count > 8'd2) ? r_hdr[2] : 8'h00;
        res.first_data    = (r_count > 8'd3) ? r_hdr[3] : 8'h00;
        res.frame_length  = r_count;
        res.is_broadcast  = (r_count > 8'd0) && (r_hdr[0] == cfg.broadcast_address);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_count   <= 8'd0;
            r_silence <= 8'd0;
            r_crc     <= CRC_INIT;
        end else begin
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_silence <= n_silence;
            r_crc     <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            if (hdr_we[i]) begin
                r_hdr[i] <= i_s_tdata;
            end
        end
    end

    // Output register with one skid entry behind it.
    assign out_fire = r_out_valid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.frame_length, r_out.first_data, r_out.register_addr,
                         r_out.function_code, r_out.station};
    assign o_m_tuser  = {r_out.is_broadcast, r_out.verdict};

endmodule

@@ dv/modbus_rtu_frame_receiver_tb.sv @@
module modbus_rtu_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrtu_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] REG_SPARE_FIRST = REG_MIN_LENGTH + 3'd1;
    localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

    // Predicts the verdict item of every addressed frame and holds the ones
    // the block still owes.
    class rtu_verdict_tracker;
        t_cfg       cfg;
        t_mode      mode;
        logic [7:0] nbytes;
        logic [7:0] quiet;
        logic [15:0] crc;
        logic [7:0] hdr [4];
        t_result    pending_verdicts[$];
        int         mismatches;

        function void clear();
            cfg.own_address       = OWN_ADDRESS_RST;
            cfg.broadcast_address = BCAST_ADDRESS_RST;
            cfg.idle_ticks        = IDLE_TICKS_RST;
            cfg.gap_ticks         = GAP_TICKS_RST;
            cfg.min_length        = MIN_LENGTH_RST;
            mode       = MODE_IDLE;
            nbytes     = 8'd0;
            quiet      = 8'd0;
            crc        = CRC_INIT;
            mismatches = 0;
            foreach (hdr[k]) hdr[k] = 8'h00;
        endfunction

        static function logic [15:0] crc_next(input logic [15:0] c_in, input logic [7:0] b);
            logic [15:0] c;
            c = c_in ^ {8'h00, b};
            repeat (8) begin
                if (c[0]) c = (c >> 1) ^ CRC_POLY;
                else      c = c >> 1;
            end
            return c;
        endfunction

        function void set_reg(input logic [2:0] idx, input logic [31:0] word);
            case (idx)
                REG_OWN_ADDRESS:   cfg.own_address       = word[7:0];
                REG_BCAST_ADDRESS: cfg.broadcast_address = word[7:0];
                REG_IDLE_TICKS:    cfg.idle_ticks        = word[7:0];
                REG_GAP_TICKS:     cfg.gap_ticks         = word[7:0];
                REG_MIN_LENGTH:    cfg.min_length        = word[7:0];
                default: ;
            endcase
        endfunction

        function void absorb_item(input logic tick, input logic [7:0] b);
            bit      gap_ok;
            t_result want;
            if (!tick) begin
                // The gap is judged on the silence seen before this byte.
                gap_ok = quiet < cfg.gap_ticks;
                quiet  = 8'd0;
                if (mode == MODE_IDLE) begin
                    if (b == cfg.own_address || b == cfg.broadcast_address) begin
                        mode   = MODE_RECEIVE;
                        nbytes = 8'd1;
                        hdr[0] = b;
                        crc    = crc_next(CRC_INIT, b);
                    end else begin
                        mode = MODE_IGNORE;
                    end
                end else if (mode == MODE_RECEIVE) begin
                    if (nbytes < 8'd4) hdr[nbytes[1:0]] = b;
                    if (nbytes < MAX_FRAME_DEFAULT && gap_ok) crc = crc_next(crc, b);
                    else mode = MODE_ERROR;
                    if (nbytes != 8'hFF) nbytes = nbytes + 8'd1;
                end
            end else if (mode != MODE_IDLE) begin
                if (quiet < cfg.idle_ticks) begin
                    quiet = quiet + 8'd1;
                end else if (mode == MODE_IGNORE) begin
                    mode   = MODE_IDLE;
                    nbytes = 8'd0;
                end else begin
                    if (mode == MODE_ERROR)                        want.verdict = VERDICT_OVERRUN;
                    else if (nbytes <= cfg.min_length)             want.verdict = VERDICT_SHORT;
                    else if (crc != 16'h0000)                      want.verdict = VERDICT_CRC_BAD;
                    else if (nbytes > 8'd1 && hdr[1] == FN_READ)
                        want.verdict = (nbytes == READ_LENGTH) ? VERDICT_READ_OK
                                                               : VERDICT_READ_LENGTH;
                    else if (nbytes > 8'd1 && hdr[1] == FN_WRITE)  want.verdict = VERDICT_WRITE_OK;
                    else                                           want.verdict = VERDICT_BAD_FUNCTION;
                    // Header fields past the end of the frame read as zero.
                    want.station       = (nbytes > 8'd0) ? hdr[0] : 8'h00;
                    want.function_code = (nbytes > 8'd1) ? hdr[1] : 8'h00;
                    want.register_addr = (nbytes > 8'd2) ? hdr[2] : 8'h00;
                    want.first_data    = (nbytes > 8'd3) ? hdr[3] : 8'h00;
                    want.frame_length  = nbytes;
                    want.is_broadcast  = (nbytes > 8'd0 && hdr[0] == cfg.broadcast_address);
                    pending_verdicts.push_back(want);
                    mode   = MODE_IDLE;
                    nbytes = 8'd0;
                    crc    = CRC_INIT;
                end
            end
        endfunction

        function string describe(input t_result r);
            return $sformatf("verdict=%0d station=%h function=%h register=%h data=%h len=%0d bcast=%b",
                             r.verdict, r.station, r.function_code, r.register_addr,
                             r.first_data, r.frame_length, r.is_broadcast);
        endfunction

        function void compare_verdict(input logic [39:0] data, input logic [3:0] user);
            t_result got;
            t_result want;
            got.station       = data[7:0];
            got.function_code = data[15:8];
            got.register_addr = data[23:16];
            got.first_data    = data[31:24];
            got.frame_length  = data[39:32];
            got.verdict       = t_verdict'(user[2:0]);
            got.is_broadcast  = user[3];
            if (pending_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected verdict item: %s", describe(got));
            end else begin
                want = pending_verdicts.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("verdict mismatch, expected: %s", describe(want));
                        $display("                  actual:   %s", describe(got));
                    end
                end
            end
        endfunction
    endclass

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = 8'h00;
    logic                  s_tuser  = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [39:0]           m_tdata;
    logic [3:0]            m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = 32'h0;
    logic [31:0]           prdata;
    logic                  pready;

    bit                 idling     = 1'b1;
    int                 stall_left = 0;
    rtu_verdict_tracker tracker    = new();

    modbus_rtu_frame_receiver DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) tracker.absorb_item(s_tuser, s_tdata);
            if (m_tvalid && m_tready) tracker.compare_verdict(m_tdata, m_tuser);
        end
    end

    always @(posedge i_clk) begin
        if (!idling) begin
            stall_left = 0;
        end else if (stall_left == 0 && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 13);
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic tick, input logic [7:0] b);
        if (idling && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= tick;
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_item(1'b1, 8'($urandom));
    endtask

    task automatic close_frame();
        send_ticks(int'(tracker.cfg.idle_ticks) + 1);
    endtask

    // Sends station, body and CRC (low byte first). A long silence goes in
    // front of byte gap_at; elsewhere up to max_pause ticks separate bytes.
    task automatic send_frame(input logic [7:0] station, input logic [7:0] body[$],
                              input bit bad_crc, input int gap_at, input int max_pause);
        logic [7:0]  bytes_q[$];
        logic [15:0] c;
        int          pause;
        bytes_q = body;
        bytes_q.push_front(station);
        c = CRC_INIT;
        foreach (bytes_q[k]) c = rtu_verdict_tracker::crc_next(c, bytes_q[k]);
        if (bad_crc) c[7:0] = c[7:0] ^ 8'($urandom_range(1, 255));
        bytes_q.push_back(c[7:0]);
        bytes_q.push_back(c[15:8]);
        foreach (bytes_q[k]) begin
            if (k == gap_at)
                pause = int'($urandom_range(tracker.cfg.gap_ticks, tracker.cfg.idle_ticks));
            else if (k > 0)
                pause = int'($urandom_range(0, max_pause));
            else
                pause = 0;
            send_ticks(pause);
            send_item(1'b0, bytes_q[k]);
        end
    endtask

    task automatic send_random_frame();
        logic [7:0] station;
        logic [7:0] body[$];
        int         pick;
        int         kind;
        int         pause_max;
        int         gap_at;
        pick = $urandom_range(0, 99);
        if (pick < 45)      station = tracker.cfg.own_address;
        else if (pick < 80) station = tracker.cfg.broadcast_address;
        else                station = 8'($urandom);
        pause_max = int'(tracker.cfg.gap_ticks) - 1;
        if (pause_max > int'(tracker.cfg.idle_ticks)) pause_max = int'(tracker.cfg.idle_ticks);
        if (pause_max > 2) pause_max = 2;
        kind = $urandom_range(0, 19);
        if (kind >= 16) begin
            // Loose bytes and ticks with no frame structure.
            repeat ($urandom_range(1, 8)) begin
                if ($urandom_range(0, 1)) send_item(1'b0, 8'($urandom));
                else send_ticks(1);
            end
            if ($urandom_range(0, 1)) close_frame();
        end else begin
            if (kind < 6) begin
                body.push_back(FN_READ);
                body.push_back(8'($urandom));
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2)) body.push_back(8'($urandom));
                if ($urandom_range(0, 7) == 0) void'(body.pop_back());
            end else if (kind < 12) begin
                body.push_back(FN_WRITE);
                repeat ($urandom_range(0, 5)) body.push_back(8'($urandom));
            end else if (kind < 15) begin
                repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
            end else begin
                repeat ($urandom_range(MAX_FRAME_DEFAULT - 4, MAX_FRAME_DEFAULT + 2))
                    body.push_back(8'($urandom));
            end
            gap_at = -1;
            if (tracker.cfg.gap_ticks <= tracker.cfg.idle_ticks && $urandom_range(0, 9) == 0)
                gap_at = int'($urandom_range(1, body.size() + 2));
            send_frame(station, body, $urandom_range(0, 7) == 0, gap_at, pause_max);
            if ($urandom_range(0, 6) == 0)
                send_ticks(int'($urandom_range(0, tracker.cfg.idle_ticks)));
            else
                close_frame();
        end
    endtask

    task automatic wait_for_verdicts();
        s_tvalid <= 1'b0;
        // Let the clock advance first so the last accepted item has been predicted.
        @(posedge i_clk);
        while (tracker.pending_verdicts.size() != 0 || m_tvalid) @(posedge i_clk);
    endtask

    // psel and penable are left high here so that back-to-back writes never
    // assign them twice in one step; apply_setting lowers them at the end.
    task automatic reg_write(input logic [2:0] idx, input logic [7:0] val);
        logic [31:0] word;
        word    = {24'($urandom), val};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        tracker.set_reg(idx, word);
    endtask

    task automatic apply_setting(input logic [7:0] own, input logic [7:0] bcast,
                                 input logic [7:0] idle, input logic [7:0] gap,
                                 input logic [7:0] min_len);
        reg_write(REG_OWN_ADDRESS, own);
        reg_write(REG_BCAST_ADDRESS, bcast);
        reg_write(REG_IDLE_TICKS, idle);
        reg_write(REG_GAP_TICKS, gap);
        reg_write(REG_MIN_LENGTH, min_len);
        // Writes above the last register must change nothing.
        reg_write(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 8'($urandom));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input int frames);
        repeat (frames) begin
            send_random_frame();
            if ($urandom_range(0, 14) == 0) wait_for_verdicts();
        end
        close_frame();
        wait_for_verdicts();
    endtask

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        tracker.clear();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_phase(3);

        // Directed frames: one tick closes nothing, two end the frame, and
        // a single tick between bytes already counts as a gap.
        apply_setting(8'hFF, 8'h00, 8'd1, 8'd1, 8'd2);
        send_ticks(1);
        send_frame(8'hFF, '{FN_READ, 8'h00}, 1'b0, -1, 0);
        close_frame();
        send_item(1'b0, 8'h7E);
        send_item(1'b0, 8'hFF);
        close_frame();
        send_frame(8'h00, '{FN_WRITE, 8'hFF, 8'h80}, 1'b0, -1, 0);
        close_frame();
        send_frame(8'hFF, '{FN_READ, 8'h12, 8'h34}, 1'b0, -1, 0);
        close_frame();
        send_frame(8'hFF, '{8'h41, 8'h00}, 1'b1, -1, 0);
        close_frame();
        send_frame(8'hFF, '{8'h41}, 1'b0, -1, 0);
        close_frame();
        send_item(1'b0, 8'h00);
        close_frame();
        send_frame(8'hFF, '{FN_WRITE, 8'h01, 8'h02}, 1'b0, 2, 0);
        close_frame();
        wait_for_verdicts();

        apply_setting(8'($urandom), 8'($urandom), 8'd3, 8'd2, 8'd4);
        run_phase(10);
        apply_setting(8'h00, 8'hFF, 8'd255, 8'd255, 8'd0);
        run_phase(1);
        apply_setting(8'hFF, 8'hFF, 8'd1, 8'd1, 8'd255);
        run_phase(6);
        repeat (3) begin
            apply_setting(8'($urandom), 8'($urandom), 8'($urandom_range(1, 6)),
                          8'($urandom_range(1, 7)), 8'($urandom_range(0, 6)));
            run_phase(6);
        end

        idling = 1'b0;
        apply_setting(8'($urandom), 8'($urandom), 8'($urandom_range(1, 6)),
                      8'($urandom_range(1, 7)), 8'($urandom_range(0, 6)));
        run_phase(10);

        if (tracker.mismatches == 0 && tracker.pending_verdicts.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
